@@ hw/rtl/fvn_pkg.sv @@
package fvn_pkg;

	// Octave chain length
	localparam int MAX_OCTAVES = 8;
	localparam int OCT_W       = $clog2(MAX_OCTAVES + 1);

	// Datapath widths
	localparam int N_W    = 26;                                // signed octave value, Q1.24
	localparam int PROD_W = N_W + 33;                          // n * amp
	localparam int SUM_W  = PROD_W + $clog2(MAX_OCTAVES);      // weighted sum
	localparam int NORM_W = 32 + $clog2(MAX_OCTAVES);          // sum of weights
	localparam int DEN_W  = NORM_W + 9;                        // weights * 512
	localparam int Q_W    = 17;                                // quotient bits incl. overflow
	localparam int CMP_W  = (SUM_W > DEN_W + Q_W - 1) ? SUM_W : DEN_W + Q_W - 1;

	// Output queue
	localparam int FIFO_DEPTH = 128;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int OCC_W      = FIFO_AW + 1;

	// Hash and format constants
	localparam logic [31:0]          HASH_X    = 32'd374761393;
	localparam logic [31:0]          HASH_Z    = 32'd668265263;
	localparam logic [31:0]          HASH_S    = 32'd2246822519;
	localparam logic [31:0]          HASH_M    = 32'd1274126177;
	localparam logic [31:0]          SEED_STEP = 32'd131;
	localparam logic [31:0]          AMP_ONE   = 32'd16384;
	localparam logic signed [N_W-1:0] VAL_ONE  = 26'sh1000000;

	// Register map
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_SEED       = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OCTAVES    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LACUNARITY = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BASE_FREQ  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_RIDGED     = 3'd5;

	typedef struct packed {
		logic [31:0]      seed;
		logic [OCT_W-1:0] count;
		logic [15:0]      gain;
		logic [15:0]      lacunarity;
		logic             ridged;
	} cfg_t;

	typedef struct packed {
		logic signed [31:0]      x;
		logic signed [31:0]      z;
		logic [31:0]             freq;
		logic [31:0]             amp;
		logic signed [SUM_W-1:0] sum;
		logic [NORM_W-1:0]       norm;
	} carry_t;

endpackage

@@ hw/rtl/fractal_value_noise_2d_core.sv @@
// Pipeline: input register, 8 octave cells of 9 stages each, 19-stage divider, output
// queue read register.
// Throughput: one item per cycle; the output queue (128 entries) absorbs a stalled output,
// and in_stall rises only when 128 items are accepted but not yet delivered.
// Reset: arst_n clears all valid bits, queue pointers and counters at once and loads the
// configuration registers with their defaults; no clearing pass.
module fractal_value_noise_2d_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [31:0]                  x_coord,
	input  logic signed [31:0]                  z_coord,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [15:0]                  noise_value,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [fvn_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [31:0]                         cfg_data
);

	localparam int NOCT = fvn_pkg::MAX_OCTAVES;

	// configuration registers
	logic [31:0] seed_q;
	logic [3:0]  octaves_q;
	logic [15:0] gain_q;
	logic [15:0] lac_q;
	logic [31:0] base_freq_q;
	logic        ridged_q;

	fvn_pkg::cfg_t cfg_w;

	logic            acc_w;
	logic            vld_s0;
	fvn_pkg::carry_t carry_s0;

	logic            chain_v [NOCT+1];
	fvn_pkg::carry_t chain_c [NOCT+1];

	logic               div_valid;
	logic signed [15:0] div_res;

	logic [15:0]                 fifo_mem [fvn_pkg::FIFO_DEPTH];
	logic [fvn_pkg::FIFO_AW-1:0] wr_ptr_q, rd_ptr_q, rd_next_w;
	logic [fvn_pkg::OCC_W-1:0]   fcnt_q, occ_q;
	logic [15:0]                 rdata_q;
	logic                        pop_w;

	// Configuration port: always ready, unknown indexes drop.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q      <= '0;
			octaves_q   <= 4'd4;
			gain_q      <= 16'd8192;
			lac_q       <= 16'd8192;
			base_freq_q <= 32'h01000000;
			ridged_q    <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				fvn_pkg::REG_SEED:       seed_q      <= cfg_data;
				fvn_pkg::REG_OCTAVES:    octaves_q   <= cfg_data[3:0];
				fvn_pkg::REG_GAIN:       gain_q      <= cfg_data[15:0];
				fvn_pkg::REG_LACUNARITY: lac_q       <= cfg_data[15:0];
				fvn_pkg::REG_BASE_FREQ:  base_freq_q <= cfg_data;
				fvn_pkg::REG_RIDGED:     ridged_q    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Clamp the octave count: zero counts as one, anything above the chain length as the
	// chain length. Cells past the count pass the sums through untouched.
	always_comb begin
		cfg_w.seed       = seed_q;
		cfg_w.gain       = gain_q;
		cfg_w.lacunarity = lac_q;
		cfg_w.ridged     = ridged_q;
		if (octaves_q == 4'd0) begin
			cfg_w.count = fvn_pkg::OCT_W'(1);
		end else if (32'(octaves_q) > NOCT) begin
			cfg_w.count = fvn_pkg::OCT_W'(NOCT);
		end else begin
			cfg_w.count = fvn_pkg::OCT_W'(octaves_q);
		end
	end

	// Input register: seed the running frequency, amplitude and sums for octave zero.
	assign acc_w = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s0 <= 1'b0;
		end else begin
			vld_s0 <= acc_w;
		end
	end

	always_ff @(posedge clk) begin
		carry_s0.x    <= x_coord;
		carry_s0.z    <= z_coord;
		carry_s0.freq <= base_freq_q;
		carry_s0.amp  <= fvn_pkg::AMP_ONE;
		carry_s0.sum  <= '0;
		carry_s0.norm <= '0;
	end

	assign chain_v[0] = vld_s0;
	assign chain_c[0] = carry_s0;

	// One cell per octave; each hands its item, frequency, amplitude and partial sums on.
	for (genvar k = 0; k < NOCT; k++) begin : g_cell
		fvn_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cfg      (cfg_w),
			.oct_idx  (fvn_pkg::OCT_W'(k)),
			.up_valid (chain_v[k]),
			.up_carry (chain_c[k]),
			.dn_valid (chain_v[k+1]),
			.dn_carry (chain_c[k+1])
		);
	end

	// Normalize: weighted sum over 512 times the weight total, truncated toward zero.
	fvn_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (chain_v[NOCT]),
		.sum      (chain_c[NOCT].sum),
		.norm     (chain_c[NOCT].norm),
		.dn_valid (div_valid),
		.result   (div_res)
	);

	// Output queue. The pipeline never stalls; instead the input is held off once the
	// queue could not take every item still in flight. The read register always holds
	// the head entry, with a bypass when the head is written in the same cycle.
	assign pop_w     = out_valid && !out_stall;
	assign rd_next_w = rd_ptr_q + fvn_pkg::FIFO_AW'(pop_w);

	always_ff @(posedge clk) begin
		if (div_valid) begin
			fifo_mem[wr_ptr_q] <= div_res;
		end
		if (div_valid && (wr_ptr_q == rd_next_w)) begin
			rdata_q <= div_res;
		end else begin
			rdata_q <= fifo_mem[rd_next_w];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fcnt_q   <= '0;
			occ_q    <= '0;
		end else begin
			if (div_valid) begin
				wr_ptr_q <= wr_ptr_q + fvn_pkg::FIFO_AW'(1);
			end
			rd_ptr_q <= rd_next_w;
			fcnt_q   <= fcnt_q + fvn_pkg::OCC_W'(div_valid) - fvn_pkg::OCC_W'(pop_w);
			occ_q    <= occ_q + fvn_pkg::OCC_W'(acc_w) - fvn_pkg::OCC_W'(pop_w);
		end
	end

	assign in_stall    = occ_q >= fvn_pkg::OCC_W'(fvn_pkg::FIFO_DEPTH);
	assign out_valid   = fcnt_q != '0;
	assign noise_value = rdata_q;

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= fvn_pkg::OCC_W'(fvn_pkg::FIFO_DEPTH))
		else $error("outstanding item count above queue depth");

	a_fifo_le_occ: assert property (@(posedge clk) disable iff (!arst_n)
		fcnt_q <= occ_q)
		else $error("queue holds more items than were accepted");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		div_valid |-> (fcnt_q < fvn_pkg::OCC_W'(fvn_pkg::FIFO_DEPTH)))
		else $error("result written into a full queue");

endmodule

@@ hw/rtl/fvn_cell.sv @@
module fvn_cell (
	input  logic                        clk,
	input  logic                        arst_n,
	input  fvn_pkg::cfg_t               cfg,
	input  logic [fvn_pkg::OCT_W-1:0]   oct_idx,
	input  logic                        up_valid,
	input  fvn_pkg::carry_t             up_carry,
	output logic                        dn_valid,
	output fvn_pkg::carry_t             dn_carry
);

	function automatic logic [31:0] sat32(input logic [35:0] v);
		sat32 = (|v[35:32]) ? 32'hffffffff : v[31:0];
	endfunction

	// a + floor((b - a) * u / 65536)
	function automatic logic [23:0] blend(input logic [23:0] a, input logic [23:0] b,
		input logic [16:0] u);
		logic signed [24:0] dif;
		logic signed [42:0] prod;
		logic signed [42:0] sh;
		dif   = $signed({1'b0, b}) - $signed({1'b0, a});
		prod  = dif * $signed({1'b0, u});
		sh    = prod >>> 16;
		blend = 24'({19'b0, a} + sh);
	endfunction

	logic [8:0] vld_q;

	fvn_pkg::carry_t c_s1, c_s2, c_s3, c_s4, c_s5, c_s6, c_s7, c_s8, c_s9;
	fvn_pkg::carry_t c2_w, c9_w;

	logic signed [64:0] px_s1, pz_s1;
	logic [31:0]        hs_q;

	logic [31:0] cx_w, cz_w;
	logic [15:0] fr_w [2];
	logic [31:0] sq_w [2];
	logic [47:0] fprod_w;
	logic [31:0] hx_s2, hz_s2;
	logic [15:0] fr_s2 [2];
	logic [15:0] t2_s2 [2];

	logic [31:0] hb_w;
	logic [31:0] hc_w [4];
	logic [31:0] cube_w [2];
	logic [21:0] g_w [2];
	logic [31:0] pre_s3 [4];
	logic [15:0] t3_s3 [2];
	logic [19:0] g_s3 [2];

	logic [35:0] fg_w [2];
	logic [31:0] m_s4 [4];
	logic [16:0] fade_s4 [2];

	logic [23:0] val_w [4];
	logic [23:0] r0_s5, r1_s5;
	logic [16:0] fz_s5;

	logic [23:0] r_s6;

	logic signed [fvn_pkg::N_W-1:0] nb_w, mag_w, n_w;
	logic signed [fvn_pkg::N_W-1:0] n_s7;

	logic signed [fvn_pkg::PROD_W-1:0] prod_s8;

	logic        act_w;
	logic [47:0] aprod_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[7:0], up_valid};
		end
	end

	// stage 1: scale point by frequency, seed hash term
	always_ff @(posedge clk) begin
		c_s1  <= up_carry;
		px_s1 <= up_carry.x * $signed({1'b0, up_carry.freq});
		pz_s1 <= up_carry.z * $signed({1'b0, up_carry.freq});
		hs_q  <= (cfg.seed + 32'(oct_idx) * fvn_pkg::SEED_STEP) * fvn_pkg::HASH_S;
	end

	// stage 2: lattice cell, fraction, corner hash terms, next frequency
	always_comb begin
		cx_w    = {{8{px_s1[63]}}, px_s1[63:40]};
		cz_w    = {{8{pz_s1[63]}}, pz_s1[63:40]};
		fr_w[0] = px_s1[39:24];
		fr_w[1] = pz_s1[39:24];
		sq_w[0] = fr_w[0] * fr_w[0];
		sq_w[1] = fr_w[1] * fr_w[1];
		fprod_w = c_s1.freq * cfg.lacunarity;
		c2_w      = c_s1;
		c2_w.freq = sat32(fprod_w[47:12]);
	end

	always_ff @(posedge clk) begin
		c_s2     <= c2_w;
		hx_s2    <= cx_w * fvn_pkg::HASH_X;
		hz_s2    <= cz_w * fvn_pkg::HASH_Z;
		fr_s2[0] <= fr_w[0];
		fr_s2[1] <= fr_w[1];
		t2_s2[0] <= sq_w[0][31:16];
		t2_s2[1] <= sq_w[1][31:16];
	end

	// stage 3: corner sums and first mix, fade terms
	always_comb begin
		hb_w    = hx_s2 + hz_s2 + hs_q;
		hc_w[0] = hb_w;
		hc_w[1] = hb_w + fvn_pkg::HASH_X;
		hc_w[2] = hb_w + fvn_pkg::HASH_Z;
		hc_w[3] = hb_w + fvn_pkg::HASH_X + fvn_pkg::HASH_Z;
		for (int a = 0; a < 2; a++) begin
			cube_w[a] = t2_s2[a] * fr_s2[a];
			g_w[a]    = 22'd655360 + 22'(t2_s2[a]) * 22'd6 - 22'(fr_s2[a]) * 22'd15;
		end
	end

	always_ff @(posedge clk) begin
		c_s3 <= c_s2;
		for (int i = 0; i < 4; i++) begin
			pre_s3[i] <= hc_w[i] ^ (hc_w[i] >> 13);
		end
		for (int a = 0; a < 2; a++) begin
			t3_s3[a] <= cube_w[a][31:16];
			g_s3[a]  <= g_w[a][19:0];
		end
	end

	// stage 4: final hash multiply, fade product
	always_comb begin
		for (int a = 0; a < 2; a++) begin
			fg_w[a] = t3_s3[a] * g_s3[a];
		end
	end

	always_ff @(posedge clk) begin
		c_s4 <= c_s3;
		for (int i = 0; i < 4; i++) begin
			m_s4[i] <= pre_s3[i] * fvn_pkg::HASH_M;
		end
		for (int a = 0; a < 2; a++) begin
			fade_s4[a] <= (fg_w[a][35:16] > 20'd65536) ? 17'd65536 : fg_w[a][32:16];
		end
	end

	// stage 5: corner values, blend along x
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			val_w[i] = m_s4[i][23:0] ^ {8'b0, m_s4[i][31:16]};
		end
	end

	always_ff @(posedge clk) begin
		c_s5  <= c_s4;
		r0_s5 <= blend(val_w[0], val_w[1], fade_s4[0]);
		r1_s5 <= blend(val_w[2], val_w[3], fade_s4[0]);
		fz_s5 <= fade_s4[1];
	end

	// stage 6: blend along z
	always_ff @(posedge clk) begin
		c_s6 <= c_s5;
		r_s6 <= blend(r0_s5, r1_s5, fz_s5);
	end

	// stage 7: map to -1..1, ridged fold
	always_comb begin
		nb_w  = $signed({1'b0, r_s6, 1'b0}) - fvn_pkg::VAL_ONE;
		mag_w = nb_w[fvn_pkg::N_W-1] ? -nb_w : nb_w;
		n_w   = cfg.ridged ? fvn_pkg::VAL_ONE - (mag_w <<< 1) : nb_w;
	end

	always_ff @(posedge clk) begin
		c_s7 <= c_s6;
		n_s7 <= n_w;
	end

	// stage 8: weight by amplitude
	always_ff @(posedge clk) begin
		c_s8    <= c_s7;
		prod_s8 <= n_s7 * $signed({1'b0, c_s7.amp});
	end

	// stage 9: accumulate, next amplitude
	always_comb begin
		act_w   = oct_idx < cfg.count;
		aprod_w = c_s8.amp * cfg.gain;
		c9_w     = c_s8;
		c9_w.amp = sat32({2'b0, aprod_w[47:14]});
		if (act_w) begin
			c9_w.sum  = c_s8.sum + fvn_pkg::SUM_W'(prod_s8);
			c9_w.norm = c_s8.norm + fvn_pkg::NORM_W'(c_s8.amp);
		end
	end

	always_ff @(posedge clk) begin
		c_s9 <= c9_w;
	end

	assign dn_valid = vld_q[8];
	assign dn_carry = c_s9;

endmodule

@@ hw/rtl/fvn_div.sv @@
module fvn_div (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                up_valid,
	input  logic signed [fvn_pkg::SUM_W-1:0]    sum,
	input  logic [fvn_pkg::NORM_W-1:0]          norm,
	output logic                                dn_valid,
	output logic signed [15:0]                  result
);

	localparam int QW = fvn_pkg::Q_W;

	logic [QW+1:0]                 vld_q;
	logic [fvn_pkg::CMP_W-1:0]     rem_s [QW+1];
	logic [fvn_pkg::DEN_W-1:0]     den_s [QW+1];
	logic [QW-1:0]                 quo_s [QW+1];
	logic                          neg_s [QW+1];
	logic signed [15:0]            res_s;
	logic [fvn_pkg::SUM_W-1:0]     abs_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[QW:0], up_valid};
		end
	end

	// take magnitude, scale divisor
	always_comb begin
		abs_w = sum[fvn_pkg::SUM_W-1] ? fvn_pkg::SUM_W'(-sum) : fvn_pkg::SUM_W'(sum);
	end

	always_ff @(posedge clk) begin
		rem_s[0] <= fvn_pkg::CMP_W'(abs_w);
		den_s[0] <= {norm, 9'b0};
		quo_s[0] <= '0;
		neg_s[0] <= sum[fvn_pkg::SUM_W-1];
	end

	// one restoring step per stage, most significant quotient bit first
	for (genvar i = 0; i < QW; i++) begin : g_step
		logic [fvn_pkg::CMP_W-1:0] sub_w;
		assign sub_w = fvn_pkg::CMP_W'(den_s[i]) << (QW - 1 - i);
		always_ff @(posedge clk) begin
			den_s[i+1] <= den_s[i];
			neg_s[i+1] <= neg_s[i];
			if (rem_s[i] >= sub_w) begin
				rem_s[i+1] <= rem_s[i] - sub_w;
				quo_s[i+1] <= {quo_s[i][QW-2:0], 1'b1};
			end else begin
				rem_s[i+1] <= rem_s[i];
				quo_s[i+1] <= {quo_s[i][QW-2:0], 1'b0};
			end
		end
	end

	// apply sign and clamp to Q1.15
	always_ff @(posedge clk) begin
		if (neg_s[QW]) begin
			if (quo_s[QW] > 17'd32768) begin
				res_s <= 16'sh8000;
			end else begin
				res_s <= 16'(-quo_s[QW]);
			end
		end else begin
			if (quo_s[QW] > 17'd32767) begin
				res_s <= 16'sh7fff;
			end else begin
				res_s <= 16'(quo_s[QW]);
			end
		end
	end

	assign dn_valid = vld_q[QW+1];
	assign result   = res_s;

endmodule
